// ===== rtl/core/pidsp_pkg.sv =====
// Types, constants and the control program of the PID speed-to-duty core.
package pidsp_pkg;

    // Fixed field widths
    localparam int GAIN_W    = 16;             // Q8.8 gains, Q0.16 interval, PWM period
    localparam int DUTY_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int INT_W     = 40;             // integral accumulator, signed Q.16
    localparam int INT_LO_W  = 20;             // split point for the integral product
    localparam int MUL_B_W   = 21;             // signed multiplier operand B
    localparam int MUL_P_W   = GAIN_W + 1 + MUL_B_W;
    localparam int TMP_W     = GAIN_W + INT_W + 1;
    localparam int DIV_STEP  = 3;              // quotient bits per divider cycle

    // Register reset values
    localparam int SETPOINT_RST = 3000;
    localparam int GAIN_RST     = 256;
    localparam int INTERVAL_RST = 109;
    localparam int CEILING_RST  = 3500;
    localparam int FLOOR_RST    = 0;
    localparam int PERIOD_RST   = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_GAIN_P   = 3'd1,
        CFG_GAIN_I   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_INTERVAL = 3'd4,
        CFG_CEILING  = 3'd5,
        CFG_FLOOR    = 3'd6,
        CFG_PERIOD   = 3'd7
    } t_cfg_idx;

    // Datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_NOP,
        OP_IDLE,        // load error and accumulator when an item arrives
        OP_MUL_ESI,     // product = interval * error
        OP_INTEG,       // integral += product, saturating
        OP_MUL_P,       // product = Kp * error
        OP_ACC_ADD,     // acc += product
        OP_MUL_ILO,     // product = Ki * integral low part
        OP_TMP_SET,     // tmp = product
        OP_MUL_IHI,     // product = Ki * integral high part
        OP_TMP_COMB,    // tmp += product << INT_LO_W
        OP_I_BIAS,      // bias negative tmp for round toward zero
        OP_ACC_ADD_I,   // acc += tmp >>> 16
        OP_DIFF,        // error difference magnitude and sign, store error
        OP_MUL_D,       // product = Kd * |de|
        OP_DIV_D,       // start divider: (product << 16) / interval
        OP_DIV_WAIT,
        OP_ACC_ADD_D,   // acc +/-= quotient
        OP_MAG,         // magnitude of acc, drop fraction
        OP_CLAMP,       // clamp to [floor, ceiling]
        OP_MUL_DUTY,    // product = period * target
        OP_DIV_Q,       // start divider: product / span
        OP_DUTY_SAT,    // saturate quotient to duty
        OP_DUTY_ZERO,
        OP_EMIT         // load output register
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE,      // advance
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_SI_ZERO,
        COND_DIV_BUSY,
        COND_NO_SPAN,
        COND_OUT_BUSY
    } t_cond;

    localparam int PC_W = 5;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Jump labels
    localparam logic [PC_W-1:0] L_IDLE      = 5'd0;
    localparam logic [PC_W-1:0] L_DIVD_WAIT = 5'd14;
    localparam logic [PC_W-1:0] L_MAG       = 5'd16;
    localparam logic [PC_W-1:0] L_DIVQ_WAIT = 5'd20;
    localparam logic [PC_W-1:0] L_DUTY_ZERO = 5'd22;
    localparam logic [PC_W-1:0] L_EMIT      = 5'd23;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: jump to target when the condition holds, else advance
    function automatic t_uword uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = uw(OP_IDLE,      COND_NO_ITEM,  L_IDLE);
            5'd1:    w = uw(OP_MUL_ESI,   COND_NONE,     L_IDLE);
            5'd2:    w = uw(OP_INTEG,     COND_NONE,     L_IDLE);
            5'd3:    w = uw(OP_MUL_P,     COND_NONE,     L_IDLE);
            5'd4:    w = uw(OP_ACC_ADD,   COND_NONE,     L_IDLE);
            5'd5:    w = uw(OP_MUL_ILO,   COND_NONE,     L_IDLE);
            5'd6:    w = uw(OP_TMP_SET,   COND_NONE,     L_IDLE);
            5'd7:    w = uw(OP_MUL_IHI,   COND_NONE,     L_IDLE);
            5'd8:    w = uw(OP_TMP_COMB,  COND_NONE,     L_IDLE);
            5'd9:    w = uw(OP_I_BIAS,    COND_NONE,     L_IDLE);
            5'd10:   w = uw(OP_ACC_ADD_I, COND_NONE,     L_IDLE);
            5'd11:   w = uw(OP_DIFF,      COND_SI_ZERO,  L_MAG);
            5'd12:   w = uw(OP_MUL_D,     COND_NONE,     L_IDLE);
            5'd13:   w = uw(OP_DIV_D,     COND_NONE,     L_IDLE);
            5'd14:   w = uw(OP_DIV_WAIT,  COND_DIV_BUSY, L_DIVD_WAIT);
            5'd15:   w = uw(OP_ACC_ADD_D, COND_NONE,     L_IDLE);
            5'd16:   w = uw(OP_MAG,       COND_NONE,     L_IDLE);
            5'd17:   w = uw(OP_CLAMP,     COND_NO_SPAN,  L_DUTY_ZERO);
            5'd18:   w = uw(OP_MUL_DUTY,  COND_NONE,     L_IDLE);
            5'd19:   w = uw(OP_DIV_Q,     COND_NONE,     L_IDLE);
            5'd20:   w = uw(OP_DIV_WAIT,  COND_DIV_BUSY, L_DIVQ_WAIT);
            5'd21:   w = uw(OP_DUTY_SAT,  COND_ALWAYS,   L_EMIT);
            5'd22:   w = uw(OP_DUTY_ZERO, COND_NONE,     L_IDLE);
            5'd23:   w = uw(OP_EMIT,      COND_OUT_BUSY, L_EMIT);
            5'd24:   w = uw(OP_NOP,       COND_ALWAYS,   L_IDLE);
            default: w = uw(OP_NOP,       COND_ALWAYS,   L_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/pidsp_in_if.sv =====
// Input channel: one measured speed sample per item.
interface pidsp_in_if #(
    parameter int RPM_BITS = 14
);
    logic                valid;
    logic                ready;
    logic [RPM_BITS-1:0] measured_rpm;

    modport source (output valid, output measured_rpm, input ready);
    modport sink   (input valid, input measured_rpm, output ready);
endinterface

// ===== rtl/core/pidsp_out_if.sv =====
// Output channel: duty count, speed target and clamp flag per item.
interface pidsp_out_if #(
    parameter int RPM_BITS = 14
);
    logic                valid;
    logic                ready;
    logic [15:0]         duty_count;
    logic [RPM_BITS-1:0] speed_target;
    logic                clamped;

    modport source (output valid, output duty_count, output speed_target, output clamped,
                    input ready);
    modport sink   (input valid, input duty_count, input speed_target, input clamped,
                    output ready);
endinterface

// ===== rtl/core/pidsp_div.sv =====
// Unsigned restoring divider, a few quotient bits per cycle.
module pidsp_div #(
    parameter int N_W = 47,
    parameter int D_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic [N_W-1:0] o_quo
);
    localparam int ITER  = (N_W + pidsp_pkg::DIV_STEP - 1) / pidsp_pkg::DIV_STEP;
    localparam int N_PAD = ITER * pidsp_pkg::DIV_STEP;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [N_PAD-1:0] r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [N_PAD-1:0] n_q;
    logic [D_W-1:0]   n_rem;

    always_comb begin
        logic [D_W:0] trial;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < pidsp_pkg::DIV_STEP; k++) begin
            trial = {n_rem, n_q[N_PAD-1]};
            n_q   = {n_q[N_PAD-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem  = D_W'(trial - {1'b0, r_den});
                n_q[0] = 1'b1;
            end else begin
                n_rem = trial[D_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(ITER);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= N_PAD'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q[N_W-1:0];

endmodule

// ===== rtl/core/pid_speed_to_pwm_duty_core.sv =====
// PID speed controller with clamped speed target and PWM duty scaling.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  i_speed  | in  | valid/ready          | measured_rpm[RPM_BITS]
//  o_ctl    | out | valid/ready          | duty_count[16], speed_target[RPM_BITS], clamped
//  i_cfg_*  | in  | write enable, no ack | idx[3], data[16]
//
// One item at a time runs through a microcoded sequencer: a 25-word control store
// drives one 17x21 multiplier, a 40-bit integral, a wide accumulator and a shared
// divider that retires 3 quotient bits a cycle. Most of an item's time goes to the
// two divider passes: derivative over the interval, then period*target over the span.
// Reset (synchronous, active low) loads the register defaults and clears the
// integral and previous error. The result sits in an output register, so a stalled
// sink does not hold the next sample; the sequencer waits only at its emit step
// if the previous result is still not taken.
module pid_speed_to_pwm_duty_core #(
    parameter int RPM_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pidsp_in_if.sink                             i_speed,
    pidsp_out_if.source                          o_ctl,
    input  logic                                 i_cfg_we,
    input  logic [pidsp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pidsp_pkg::CFG_W-1:0]          i_cfg_data
);
    localparam int GW      = pidsp_pkg::GAIN_W;
    localparam int E_W     = RPM_BITS + 1;        // signed error
    localparam int DM_W    = RPM_BITS + 1;        // |error difference|
    localparam int DIV_N_W = DM_W + 32;           // (Kd*|de|) << 16
    localparam int ACC_W   = RPM_BITS + 36;       // Q.8 sum of all terms
    localparam int MAG_W   = ACC_W - 8;
    localparam int INT_W   = pidsp_pkg::INT_W;
    localparam int INT_XW  = INT_W + 1;
    localparam int ILO_W   = pidsp_pkg::INT_LO_W;
    localparam int MB_W    = pidsp_pkg::MUL_B_W;
    localparam int MP_W    = pidsp_pkg::MUL_P_W;
    localparam int TMP_W   = pidsp_pkg::TMP_W;

    // Configuration registers
    logic [RPM_BITS-1:0] r_setpoint;
    logic [GW-1:0]       r_gp;
    logic [GW-1:0]       r_gi;
    logic [GW-1:0]       r_gd;
    logic [GW-1:0]       r_si;
    logic [RPM_BITS-1:0] r_ceil;
    logic [RPM_BITS-1:0] r_floor;
    logic [GW-1:0]       r_period;

    // Sequencer and controller state
    logic [pidsp_pkg::PC_W-1:0] r_pc;
    logic [pidsp_pkg::PC_W-1:0] n_pc;
    pidsp_pkg::t_uword          uword;
    logic                       take_jump;
    logic signed [INT_W-1:0]    r_integ;
    logic signed [INT_W-1:0]    n_integ;
    logic signed [E_W-1:0]      r_prev_err;

    // Datapath
    logic signed [E_W-1:0]   r_err;
    logic                    r_dneg;
    logic [DM_W-1:0]         r_dmag;
    logic signed [MP_W-1:0]  r_prod;
    logic signed [TMP_W-1:0] r_tmp;
    logic signed [ACC_W-1:0] r_acc;
    logic [MAG_W-1:0]        r_mag;
    logic [RPM_BITS-1:0]     r_target;
    logic                    r_clamped;
    logic [GW-1:0]           r_duty;

    // Output register
    logic                    r_out_valid;
    logic [GW-1:0]           r_out_duty;
    logic [RPM_BITS-1:0]     r_out_target;
    logic                    r_out_clamped;

    logic                    accept;
    logic                    out_busy;
    logic [GW-1:0]           mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic signed [INT_W:0]   integ_sum;
    logic signed [E_W:0]     de;
    logic signed [E_W:0]     de_abs;
    logic signed [ACC_W-1:0] acc_abs;
    logic signed [ACC_W-1:0] d_term;

    logic                    div_start;
    logic [DIV_N_W-1:0]      div_num;
    logic [GW-1:0]           div_den;
    logic                    div_busy;
    logic [DIV_N_W-1:0]      div_quo;

    assign uword         = pidsp_pkg::uprog(r_pc);
    assign i_speed.ready = (r_pc == pidsp_pkg::L_IDLE);
    assign accept        = i_speed.valid & i_speed.ready;
    assign out_busy      = r_out_valid & ~o_ctl.ready;

    // Next step: jump when the word's condition holds, else advance
    always_comb begin
        case (uword.cond)
            pidsp_pkg::COND_NONE:     take_jump = 1'b0;
            pidsp_pkg::COND_ALWAYS:   take_jump = 1'b1;
            pidsp_pkg::COND_NO_ITEM:  take_jump = ~accept;
            pidsp_pkg::COND_SI_ZERO:  take_jump = (r_si == '0);
            pidsp_pkg::COND_DIV_BUSY: take_jump = div_busy;
            pidsp_pkg::COND_NO_SPAN:  take_jump = (r_ceil <= r_floor);
            pidsp_pkg::COND_OUT_BUSY: take_jump = out_busy;
            default:                  take_jump = 1'b1;
        endcase
        n_pc = take_jump ? uword.target : r_pc + 1'b1;
    end

    // Shared multiplier operand select
    always_comb begin
        case (uword.op)
            pidsp_pkg::OP_MUL_ESI: begin
                mul_a = r_si;
                mul_b = MB_W'(r_err);
            end
            pidsp_pkg::OP_MUL_ILO: begin
                mul_a = r_gi;
                mul_b = MB_W'({1'b0, r_integ[ILO_W-1:0]});
            end
            pidsp_pkg::OP_MUL_IHI: begin
                mul_a = r_gi;
                mul_b = MB_W'($signed(r_integ[INT_W-1:ILO_W]));
            end
            pidsp_pkg::OP_MUL_D: begin
                mul_a = r_gd;
                mul_b = MB_W'(r_dmag);
            end
            pidsp_pkg::OP_MUL_DUTY: begin
                mul_a = r_period;
                mul_b = MB_W'(r_target);
            end
            default: begin
                mul_a = r_gp;
                mul_b = MB_W'(r_err);
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // Integral update, saturating to the 40-bit range
    always_comb begin
        integ_sum = INT_XW'(r_integ) + INT_XW'(r_prod);
        if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
            n_integ = integ_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                       : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            n_integ = integ_sum[INT_W-1:0];
        end
    end

    assign de      = (E_W+1)'(r_err) - (E_W+1)'(r_prev_err);
    assign de_abs  = de[E_W] ? -de : de;
    assign acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign d_term  = r_dneg ? -ACC_W'({1'b0, div_quo}) : ACC_W'({1'b0, div_quo});

    // Divider: derivative pass or duty pass
    assign div_start = (uword.op == pidsp_pkg::OP_DIV_D) || (uword.op == pidsp_pkg::OP_DIV_Q);
    assign div_num   = (uword.op == pidsp_pkg::OP_DIV_D) ? {r_prod[DM_W+15:0], 16'b0}
                                                         : DIV_N_W'(r_prod[RPM_BITS+15:0]);
    assign div_den   = (uword.op == pidsp_pkg::OP_DIV_D) ? r_si : GW'(r_ceil - r_floor);

    pidsp_div #(
        .N_W (DIV_N_W),
        .D_W (GW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Control state, configuration and controller memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= pidsp_pkg::L_IDLE;
            r_setpoint  <= RPM_BITS'(pidsp_pkg::SETPOINT_RST);
            r_gp        <= GW'(pidsp_pkg::GAIN_RST);
            r_gi        <= GW'(pidsp_pkg::GAIN_RST);
            r_gd        <= GW'(pidsp_pkg::GAIN_RST);
            r_si        <= GW'(pidsp_pkg::INTERVAL_RST);
            r_ceil      <= RPM_BITS'(pidsp_pkg::CEILING_RST);
            r_floor     <= RPM_BITS'(pidsp_pkg::FLOOR_RST);
            r_period    <= GW'(pidsp_pkg::PERIOD_RST);
            r_integ     <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                unique case (pidsp_pkg::t_cfg_idx'(i_cfg_idx))
                    pidsp_pkg::CFG_SETPOINT: r_setpoint <= i_cfg_data[RPM_BITS-1:0];
                    pidsp_pkg::CFG_GAIN_P:   r_gp       <= i_cfg_data;
                    pidsp_pkg::CFG_GAIN_I:   r_gi       <= i_cfg_data;
                    pidsp_pkg::CFG_GAIN_D:   r_gd       <= i_cfg_data;
                    pidsp_pkg::CFG_INTERVAL: r_si       <= i_cfg_data;
                    pidsp_pkg::CFG_CEILING:  r_ceil     <= i_cfg_data[RPM_BITS-1:0];
                    pidsp_pkg::CFG_FLOOR:    r_floor    <= i_cfg_data[RPM_BITS-1:0];
                    pidsp_pkg::CFG_PERIOD:   r_period   <= i_cfg_data;
                    default: ;
                endcase
            end

            // A zero interval gives a zero product, so the sum is unchanged
            if (uword.op == pidsp_pkg::OP_INTEG) begin
                r_integ <= n_integ;
            end
            if (uword.op == pidsp_pkg::OP_DIFF) begin
                r_prev_err <= r_err;
            end

            if (uword.op == pidsp_pkg::OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_ctl.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (uword.op)
            pidsp_pkg::OP_IDLE: begin
                if (accept) begin
                    r_err <= $signed({1'b0, r_setpoint}) - $signed({1'b0, i_speed.measured_rpm});
                    r_acc <= ACC_W'({1'b0, i_speed.measured_rpm, 8'b0});
                end
            end
            pidsp_pkg::OP_MUL_ESI,
            pidsp_pkg::OP_MUL_P,
            pidsp_pkg::OP_MUL_ILO,
            pidsp_pkg::OP_MUL_IHI,
            pidsp_pkg::OP_MUL_D,
            pidsp_pkg::OP_MUL_DUTY: r_prod <= mul_p;
            pidsp_pkg::OP_ACC_ADD:   r_acc <= r_acc + ACC_W'(r_prod);
            pidsp_pkg::OP_TMP_SET:   r_tmp <= TMP_W'(r_prod);
            pidsp_pkg::OP_TMP_COMB:  r_tmp <= (TMP_W'(r_prod) <<< ILO_W) + r_tmp;
            // Bias a negative product so the shift rounds toward zero
            pidsp_pkg::OP_I_BIAS:    r_tmp <= r_tmp + (r_tmp[TMP_W-1] ? TMP_W'(16'hFFFF) : '0);
            pidsp_pkg::OP_ACC_ADD_I: r_acc <= r_acc + ACC_W'(r_tmp >>> 16);
            pidsp_pkg::OP_DIFF: begin
                r_dneg <= de[E_W];
                r_dmag <= de_abs[DM_W-1:0];
            end
            pidsp_pkg::OP_ACC_ADD_D: r_acc <= r_acc + d_term;
            pidsp_pkg::OP_MAG:       r_mag <= acc_abs[ACC_W-1:8];
            // Ceiling test first, so a value above the ceiling yields the ceiling even when the floor lies above it
            pidsp_pkg::OP_CLAMP: begin
                if (r_mag > MAG_W'(r_ceil)) begin
                    r_target  <= r_ceil;
                    r_clamped <= 1'b1;
                end else if (r_mag < MAG_W'(r_floor)) begin
                    r_target  <= r_floor;
                    r_clamped <= 1'b1;
                end else begin
                    r_target  <= r_mag[RPM_BITS-1:0];
                    r_clamped <= 1'b0;
                end
            end
            pidsp_pkg::OP_DUTY_SAT:  r_duty <= (|div_quo[DIV_N_W-1:GW]) ? '1 : div_quo[GW-1:0];
            pidsp_pkg::OP_DUTY_ZERO: r_duty <= '0;
            pidsp_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    r_out_duty    <= r_duty;
                    r_out_target  <= r_target;
                    r_out_clamped <= r_clamped;
                end
            end
            default: ;
        endcase
    end

    assign o_ctl.valid        = r_out_valid;
    assign o_ctl.duty_count   = r_out_duty;
    assign o_ctl.speed_target = r_out_target;
    assign o_ctl.clamped      = r_out_clamped;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the PID speed-to-duty core: predictor, scoreboard, stimulus.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RPM_BITS    = 14;
    localparam int          INT_W       = pidsp_pkg::INT_W;
    localparam int          DUTY_W      = pidsp_pkg::DUTY_W;
    localparam int          GAIN_W      = pidsp_pkg::GAIN_W;
    localparam int          CFG_W       = pidsp_pkg::CFG_W;
    localparam int unsigned SPEED_MAX   = (1 << RPM_BITS) - 1;
    localparam longint      INTEG_MAX   = (64'sd1 <<< (INT_W - 1)) - 1;
    localparam longint      INTEG_MIN   = -(64'sd1 <<< (INT_W - 1));
    localparam int          CYCLE_LIMIT = 2_000_000;

    // One output item of the core, in port order.
    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [RPM_BITS-1:0] target;
        logic                clamped;
    } t_ctl;

    // Mirrors the controller registers and loop state, and queues the output item
    // that each accepted speed sample must produce.
    class duty_predictor;
        bit [RPM_BITS-1:0]        setpoint, ceil_rpm, floor_rpm;
        bit [GAIN_W-1:0]          gain_p, gain_i, gain_d, interval, period;
        bit signed [INT_W-1:0]    integ;
        bit signed [RPM_BITS:0]   prev_err;
        t_ctl                     expected_ctl[$];
        int                       mismatches;

        function new();
            setpoint   = pidsp_pkg::SETPOINT_RST;
            gain_p     = pidsp_pkg::GAIN_RST;
            gain_i     = pidsp_pkg::GAIN_RST;
            gain_d     = pidsp_pkg::GAIN_RST;
            interval   = pidsp_pkg::INTERVAL_RST;
            ceil_rpm   = pidsp_pkg::CEILING_RST;
            floor_rpm  = pidsp_pkg::FLOOR_RST;
            period     = pidsp_pkg::PERIOD_RST;
            integ      = '0;
            prev_err   = '0;
            mismatches = 0;
        endfunction

        function void load_reg(input pidsp_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] data);
            case (idx)
                pidsp_pkg::CFG_SETPOINT: setpoint  = data[RPM_BITS-1:0];
                pidsp_pkg::CFG_GAIN_P:   gain_p    = data;
                pidsp_pkg::CFG_GAIN_I:   gain_i    = data;
                pidsp_pkg::CFG_GAIN_D:   gain_d    = data;
                pidsp_pkg::CFG_INTERVAL: interval  = data;
                pidsp_pkg::CFG_CEILING:  ceil_rpm  = data[RPM_BITS-1:0];
                pidsp_pkg::CFG_FLOOR:    floor_rpm = data[RPM_BITS-1:0];
                pidsp_pkg::CFG_PERIOD:   period    = data;
                default: ;
            endcase
        endfunction

        function void take_sample(input logic [RPM_BITS-1:0] meas_in);
            longint meas, err, acc, si, p_term, i_term, d_term, de, q, total, tgt, span, duty;
            t_ctl   r;
            meas = longint'(meas_in);
            err  = longint'(setpoint) - meas;
            si   = longint'(interval);
            acc  = longint'(integ);
            // integral holds still when the interval is zero
            if (si != 0) begin
                acc = acc + err * si;
                if (acc > INTEG_MAX) acc = INTEG_MAX;
                if (acc < INTEG_MIN) acc = INTEG_MIN;
                integ = acc[INT_W-1:0];
            end
            p_term = longint'(gain_p) * err;
            i_term = (longint'(gain_i) * acc) / 65536;
            d_term = 0;
            if (si != 0) begin
                de     = err - longint'(prev_err);
                q      = ((de < 0 ? -de : de) * longint'(gain_d) * 65536) / si;
                d_term = de < 0 ? -q : q;
            end
            prev_err = err[RPM_BITS:0];

            total = meas * 256 + p_term + i_term + d_term;
            tgt   = (total < 0 ? -total : total) >>> 8;
            // ceiling test first: above the ceiling gives the ceiling even when the floor is higher
            r.clamped = 1'b0;
            if (tgt > longint'(ceil_rpm)) begin
                tgt       = longint'(ceil_rpm);
                r.clamped = 1'b1;
            end else if (tgt < longint'(floor_rpm)) begin
                tgt       = longint'(floor_rpm);
                r.clamped = 1'b1;
            end
            span = longint'(ceil_rpm) - longint'(floor_rpm);
            if (span > 0) begin
                duty = (longint'(period) * tgt) / span;
                if (duty > 65535) duty = 65535;
            end else begin
                duty = 0;
            end
            r.duty   = duty[DUTY_W-1:0];
            r.target = tgt[RPM_BITS-1:0];
            expected_ctl.push_back(r);
        endfunction

        function void match_output(input t_ctl got);
            t_ctl want;
            if (expected_ctl.size() == 0) begin
                $error("output item with none expected: duty_count %0d speed_target %0d clamped %0d",
                       got.duty, got.target, got.clamped);
                mismatches++;
                return;
            end
            want = expected_ctl.pop_front();
            if (got.duty !== want.duty) begin
                $error("duty_count: expected %0d, actual %0d", want.duty, got.duty);
                mismatches++;
            end
            if (got.target !== want.target) begin
                $error("speed_target: expected %0d, actual %0d", want.target, got.target);
                mismatches++;
            end
            if (got.clamped !== want.clamped) begin
                $error("clamped: expected %0d, actual %0d", want.clamped, got.clamped);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    pidsp_pkg::t_cfg_idx  cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   burst_left;
    int                   cycles = 0;
    duty_predictor        model = new();

    pidsp_in_if  #(.RPM_BITS(RPM_BITS)) speed_if ();
    pidsp_out_if #(.RPM_BITS(RPM_BITS)) ctl_if ();

    pid_speed_to_pwm_duty_core #(.RPM_BITS(RPM_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_speed    (speed_if.sink),
        .o_ctl      (ctl_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sample every handshake and register write at the clock edge, before any
    // driver update of that edge lands. Check the output before noting a new
    // sample so that a stray result never pairs with an item of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we)
                model.load_reg(cfg_idx, cfg_data);
            if (ctl_if.valid && ctl_if.ready)
                model.match_output({ctl_if.duty_count, ctl_if.speed_target, ctl_if.clamped});
            if (speed_if.valid && speed_if.ready)
                model.take_sample(speed_if.measured_rpm);
        end
    end

    // Output back-pressure: switch between free flow, coin-flip ready, sparse ready
    // and long stalls, so the core sometimes finishes an item while the previous
    // result is still held.
    initial begin
        int mode, left, stall;
        ctl_if.ready = 1'b0;
        left  = 0;
        stall = 0;
        mode  = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0: ctl_if.ready <= 1'b1;
                1: ctl_if.ready <= ($urandom_range(0, 1) == 1);
                2: ctl_if.ready <= ($urandom_range(0, 7) == 0);
                default: begin
                    if (stall > 0) begin
                        ctl_if.ready <= 1'b0;
                        stall--;
                    end else begin
                        ctl_if.ready <= 1'b1;
                        stall = $urandom_range(10, 60);
                    end
                end
            endcase
        end
    end

    // Drive one register; the caller drops the write enable after its last write.
    task automatic write_reg(input pidsp_pkg::t_cfg_idx idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic write_all(input int unsigned sp, gp, gi, gd, si, ceil_v, floor_v, per);
        write_reg(pidsp_pkg::CFG_SETPOINT, sp);
        write_reg(pidsp_pkg::CFG_GAIN_P, gp);
        write_reg(pidsp_pkg::CFG_GAIN_I, gi);
        write_reg(pidsp_pkg::CFG_GAIN_D, gd);
        write_reg(pidsp_pkg::CFG_INTERVAL, si);
        write_reg(pidsp_pkg::CFG_CEILING, ceil_v);
        write_reg(pidsp_pkg::CFG_FLOOR, floor_v);
        write_reg(pidsp_pkg::CFG_PERIOD, per);
        cfg_we <= 1'b0;
    endtask

    // Send one speed sample. Samples go out in bursts; between bursts hold valid
    // low for a random gap so that arrivals land on every step of the sequencer.
    task automatic send_speed(input int unsigned v);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2, 3:    gap = $urandom_range(1, 8);
                default: gap = $urandom_range(9, 60);
            endcase
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                speed_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        speed_if.valid        <= 1'b1;
        speed_if.measured_rpm <= v[RPM_BITS-1:0];
        do @(posedge i_clk); while (!speed_if.ready);
    endtask

    // Drop valid and wait until every queued result has come back. Poll on the
    // falling edge, where the sampling block of the rising edge has already run.
    task automatic end_phase();
        speed_if.valid <= 1'b0;
        @(negedge i_clk);
        while (model.expected_ctl.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick_value(input int unsigned max_v);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return max_v;
            default: return $urandom_range(0, max_v);
        endcase
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 15))
            0, 1:       return 0;
            2:          return 16'hFFFF;
            3, 4, 5, 6: return $urandom_range(0, 255);
            default:    return $urandom_range(0, 1024);
        endcase
    endfunction

    // Samples: uniform, close around the setpoint, or often pinned to the range ends.
    function automatic int unsigned next_speed(input int mode);
        int v;
        case (mode)
            0: v = $urandom_range(0, SPEED_MAX);
            1: begin
                v = int'(model.setpoint) + $urandom_range(0, 600) - 300;
                if (v < 0) v = 0;
                if (v > int'(SPEED_MAX)) v = SPEED_MAX;
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       v = 0;
                    1:       v = SPEED_MAX;
                    default: v = $urandom_range(0, SPEED_MAX);
                endcase
            end
        endcase
        return v;
    endfunction

    // Pick a full register set; windup pins the setpoint high and the interval
    // wide so the integral runs into its positive limit.
    task automatic random_settings(input bit windup);
        int unsigned sp, gp, gi, gd, si, ceil_v, floor_v, per;
        sp = windup ? SPEED_MAX : pick_value(SPEED_MAX);
        gp = pick_gain();
        gi = pick_gain();
        gd = pick_gain();
        case ($urandom_range(0, 15))
            0:          si = 0;
            1, 2:       si = 16'hFFFF;
            3, 4:       si = 1;
            5, 6, 7:    si = $urandom_range(1, 65535);
            default:    si = $urandom_range(1, 400);
        endcase
        if (windup) si = 16'hFFFF;
        ceil_v = pick_value(SPEED_MAX);
        case ($urandom_range(0, 15))
            0:       floor_v = ceil_v;
            1, 2:    floor_v = $urandom_range(0, SPEED_MAX);
            default: floor_v = $urandom_range(0, ceil_v);
        endcase
        per = pick_value(16'hFFFF);
        write_all(sp, gp, gi, gd, si, ceil_v, floor_v, per);
    endtask

    initial begin
        int random_items, n, mode;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = pidsp_pkg::CFG_SETPOINT;
        cfg_data              = '0;
        speed_if.valid        = 1'b0;
        speed_if.measured_rpm = '0;
        burst_left            = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero PWM period, so every duty is zero.
        send_speed(0);
        send_speed(SPEED_MAX);
        send_speed(3000);
        send_speed(2999);
        send_speed(3001);
        send_speed(1);
        end_phase();

        // All registers at their top values but the floor, which is zero.
        write_all(SPEED_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, SPEED_MAX, 0, 16'hFFFF);
        send_speed(0);
        send_speed(SPEED_MAX);
        send_speed(8192);
        end_phase();

        // Zero gains pass the measured speed through: hit floor, ceiling, in range,
        // and a duty that saturates.
        write_all(0, 0, 0, 0, 1, 1000, 500, 40000);
        send_speed(0);
        send_speed(SPEED_MAX);
        send_speed(700);
        end_phase();

        // Zero interval: integral frozen, no derivative.
        write_all(6000, 300, 200, 500, 0, SPEED_MAX, 100, 5000);
        send_speed(5000);
        send_speed(100);
        end_phase();

        // Floor above ceiling: the ceiling test comes first, duty is zero.
        write_all(3000, 256, 0, 0, 109, 200, 900, 30000);
        send_speed(50);
        send_speed(500);
        send_speed(5000);
        end_phase();

        // Ceiling equal to floor: no span, duty is zero.
        write_all(4000, 0, 0, 0, 109, 4000, 4000, 65535);
        send_speed(4000);
        send_speed(10);
        end_phase();

        // Random phases, each with a fresh register set.
        random_items = 0;
        while (random_items < 1250) begin
            n    = $urandom_range(20, 90);
            mode = $urandom_range(0, 2);
            random_settings(1'b0);
            repeat (n) send_speed(next_speed(mode));
            end_phase();
            random_items += n;
        end

        // Drive the integral into saturation, varying the other settings on the way.
        repeat (6) begin
            random_settings(1'b1);
            repeat (100) send_speed($urandom_range(0, 63));
            end_phase();
        end

        // Let any late output show up before judging.
        repeat (100) @(posedge i_clk);
        if (model.expected_ctl.size() != 0) begin
            $error("%0d output items never arrived", model.expected_ctl.size());
            model.mismatches++;
        end
        if (model.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pidsp_pkg.sv
rtl/core/pidsp_in_if.sv
rtl/core/pidsp_out_if.sv
rtl/core/pidsp_div.sv
rtl/core/pid_speed_to_pwm_duty_core.sv
dv/testbench.sv
